>>> rtl/core/triangle_unit_normal_assert.svh
// assertion macros shared by the triangle normal rtl
`ifndef TRIANGLE_UNIT_NORMAL_ASSERT_SVH
`define TRIANGLE_UNIT_NORMAL_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off while in reset
`define TUN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TUN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/tun_pkg.sv
// shared types and constants of the triangle normal unit
package tun_pkg;

  localparam int IdxW       = 13;   // width of a vertex or corner index
  localparam int IdxExtW    = 17;   // index width that can hold the largest depth
  localparam int RedW       = 31;   // width of a reduced cross magnitude
  localparam int SumW       = 64;   // sum of three squared magnitudes
  localparam int RootW      = 32;   // integer square root width
  localparam int RemW       = 34;   // square root remainder width
  localparam int FracW      = 15;   // fraction bits of the result
  localparam int QuotW      = 16;   // quotient bits of the divider
  localparam int NumW       = RedW + FracW + 1;
  localparam int OutW       = 16;   // result component width
  localparam int QueueDepth = 4;

  typedef enum logic [1:0] {
    FeIdle,
    FeReadB,
    FeReadC
  } tun_fe_state_e;

  // per-item payload that rides along the root and divide pipelines
  typedef struct packed {
    logic [2:0][RedW-1:0] r;
    logic [2:0]           neg;
    logic                 degen;
  } tun_norm_t;

endpackage

>>> rtl/core/triangle_unit_normal.sv
// top level of the triangle unit normal block
//
//  port group   dir   carries
//  s_axis       in    vertex loads and triangle requests, tuser = action
//  m_axis       out   one unit normal per triangle, tuser = degenerate
//
//  a load is a single ram write; the corners of a triangle are read one after
//  another through the single port of the vertex ram
//  the math pipeline behind the queue takes a new triangle every cycle
//  while m_axis does not stall
//  rst_ni clears control only; vertex ram contents stay undefined until written
//  a stall on m_axis freezes the pipeline; the queue lets loads and fetches go on
`include "triangle_unit_normal_assert.svh"
module triangle_unit_normal import tun_pkg::*; #(
  parameter int VERTEX_DEPTH = 4096,
  parameter int COORD_WIDTH  = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // vertex_index, coord_x, coord_y, coord_z, corner_a, corner_b, corner_c, zero fill
  input  logic [((6*IdxW/2+IdxW+3*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // action
  input  logic                    s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // normal_x, normal_y, normal_z
  output logic [3*OutW-1:0]       m_axis_tdata,
  // degenerate
  output logic                    m_axis_tuser
);

  localparam int Cw    = COORD_WIDTH;
  localparam int ItemW = 9 * Cw;
  localparam int OffX  = IdxW;
  localparam int OffA  = IdxW + 3 * Cw;

  logic             fe_push, fq_valid, fq_pop, fq_full, fq_afull;
  logic [ItemW-1:0] fe_data, fq_data;
  logic [OutW-1:0]  nx, ny, nz;

  tun_front #(
    .VERTEX_DEPTH (VERTEX_DEPTH),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (s_axis_tvalid),
    .ready_o        (s_axis_tready),
    .action_i       (s_axis_tuser),
    .vertex_index_i (s_axis_tdata[IdxW-1:0]),
    .coord_x_i      (s_axis_tdata[OffX +: Cw]),
    .coord_y_i      (s_axis_tdata[OffX + Cw +: Cw]),
    .coord_z_i      (s_axis_tdata[OffX + 2*Cw +: Cw]),
    .corner_a_i     (s_axis_tdata[OffA +: IdxW]),
    .corner_b_i     (s_axis_tdata[OffA + IdxW +: IdxW]),
    .corner_c_i     (s_axis_tdata[OffA + 2*IdxW +: IdxW]),
    .room_i         (!fq_afull),
    .push_o         (fe_push),
    .push_data_o    (fe_data)
  );

  tun_fifo #(
    .WIDTH (ItemW),
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_push),
    .data_i  (fe_data),
    .pop_i   (fq_pop),
    .valid_o (fq_valid),
    .data_o  (fq_data),
    .full_o  (fq_full),
    .afull_o (fq_afull)
  );

  logic be_ready;
  assign fq_pop = fq_valid && be_ready;

  tun_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (fq_valid),
    .ready_o      (be_ready),
    .data_i       (fq_data),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .normal_x_o   (nx),
    .normal_y_o   (ny),
    .normal_z_o   (nz),
    .degenerate_o (m_axis_tuser)
  );

  assign m_axis_tdata = {nz, ny, nx};

  logic tri_take, m_degen;
  assign tri_take = s_axis_tvalid && s_axis_tready && s_axis_tuser;
  assign m_degen  = m_axis_tvalid && m_axis_tuser;

  `TUN_ASSERT_NOW(a_queue_no_overflow, fe_push && !fq_pop, !fq_full, "corner queue overflow")
  `TUN_ASSERT_NOW(a_degen_is_zero, m_degen, m_axis_tdata == '0, "degenerate normal not zero")
  `TUN_ASSERT_NEXT(a_tri_blocks_port, tri_take, !s_axis_tready, "triangle fetch overlapped")

endmodule

>>> rtl/core/tun_ram.sv
// generic single-port ram with registered read
module tun_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/tun_fifo.sv
// small flip-flop queue between the vertex front end and the math back end
module tun_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             afull_o
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             pop;

  assign pop     = pop_i && (cnt_q != '0);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign afull_o = (cnt_q >= CntW'(DEPTH - 1));

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/core/tun_front.sv
// front end: takes items, writes vertices, fetches the three corners of a triangle
module tun_front import tun_pkg::*; #(
  parameter int VERTEX_DEPTH = 4096,
  parameter int COORD_WIDTH  = 24
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic                     action_i,
  input  logic [IdxW-1:0]          vertex_index_i,
  input  logic [COORD_WIDTH-1:0]   coord_x_i,
  input  logic [COORD_WIDTH-1:0]   coord_y_i,
  input  logic [COORD_WIDTH-1:0]   coord_z_i,
  input  logic [IdxW-1:0]          corner_a_i,
  input  logic [IdxW-1:0]          corner_b_i,
  input  logic [IdxW-1:0]          corner_c_i,
  input  logic                     room_i,
  output logic                     push_o,
  output logic [9*COORD_WIDTH-1:0] push_data_o
);

  localparam int AddrW = $clog2(VERTEX_DEPTH);
  localparam int VtxW  = 3 * COORD_WIDTH;

  tun_fe_state_e    state_q, state_d;
  logic [IdxW-1:0]  corner_b_q, corner_c_q;
  logic [IdxW-1:0]  sel_idx;
  logic [IdxExtW-1:0] sel_ext;
  logic [AddrW-1:0] addr;
  logic             sel_ok, we, accept;
  logic             rd_a_q, rd_b_q, rd_c_q, zero_q;
  logic             rd_a_d, rd_b_d, rd_c_d;
  logic [VtxW-1:0]  rdata, rdata_z, va_q, vb_q;

  assign accept  = valid_i && ready_o;
  assign ready_o = (state_q == FeIdle) && room_i;
  assign sel_ext = IdxExtW'(sel_idx) - IdxExtW'(1);
  assign addr    = sel_ext[AddrW-1:0];
  assign sel_ok  = (sel_idx != '0) && (IdxExtW'(sel_idx) <= IdxExtW'(VERTEX_DEPTH));

  always_comb begin
    state_d = state_q;
    sel_idx = corner_a_i;
    we      = 1'b0;
    rd_a_d  = 1'b0;
    rd_b_d  = 1'b0;
    rd_c_d  = 1'b0;
    case (state_q)
      FeIdle: begin
        sel_idx = action_i ? corner_a_i : vertex_index_i;
        if (accept) begin
          if (action_i) begin
            rd_a_d  = 1'b1;
            state_d = FeReadB;
          end else begin
            we = sel_ok;
          end
        end
      end
      FeReadB: begin
        sel_idx = corner_b_q;
        rd_b_d  = 1'b1;
        state_d = FeReadC;
      end
      FeReadC: begin
        sel_idx = corner_c_q;
        rd_c_d  = 1'b1;
        state_d = FeIdle;
      end
      default: state_d = FeIdle;
    endcase
  end

  tun_ram #(
    .WIDTH (VtxW),
    .DEPTH (VERTEX_DEPTH)
  ) u_vtx_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (addr),
    .wdata_i ({coord_z_i, coord_y_i, coord_x_i}),
    .rdata_o (rdata)
  );

  // corners outside the table read as the origin
  assign rdata_z = zero_q ? '0 : rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FeIdle;
      rd_a_q  <= 1'b0;
      rd_b_q  <= 1'b0;
      rd_c_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_a_q  <= rd_a_d;
      rd_b_q  <= rd_b_d;
      rd_c_q  <= rd_c_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q <= !sel_ok;
    if (accept) begin
      corner_b_q <= corner_b_i;
      corner_c_q <= corner_c_i;
    end
    if (rd_a_q) begin
      va_q <= rdata_z;
    end
    if (rd_b_q) begin
      vb_q <= rdata_z;
    end
  end

  assign push_o      = rd_c_q;
  assign push_data_o = {rdata_z, vb_q, va_q};

endmodule

>>> rtl/core/tun_back.sv
// back end: cross product, normalize, square root and divide pipeline
module tun_back import tun_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic [9*COORD_WIDTH-1:0] data_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic [OutW-1:0]          normal_x_o,
  output logic [OutW-1:0]          normal_y_o,
  output logic [OutW-1:0]          normal_z_o,
  output logic                     degenerate_o
);

  localparam int Cw   = COORD_WIDTH;
  localparam int DifW = Cw + 1;
  localparam int PrdW = 2 * DifW;
  localparam int CrsW = PrdW + 1;
  localparam int LenW = $clog2(CrsW + 1);
  localparam int ExtW = CrsW + RedW;

  logic en;
  assign en      = !valid_o || ready_i;
  assign ready_o = en;

  // stage 1: edge vectors
  logic                   v1_q;
  logic signed [DifW-1:0] u_q [3];
  logic signed [DifW-1:0] w_q [3];
  // stage 2: products
  logic                   v2_q;
  logic signed [PrdW-1:0] p_q [6];
  // stage 3: cross magnitudes
  logic                   v3_q;
  logic [CrsW-1:0]        m3_q [3];
  logic [2:0]             neg3_q;
  // stage 4: bit length
  logic                   v4_q;
  logic [CrsW-1:0]        m4_q [3];
  logic [2:0]             neg4_q;
  logic [LenW-1:0]        bl_q;
  // stage 5: reduced magnitudes
  logic                   v5_q;
  tun_norm_t              pay5_q;
  // stage 6: squares
  logic                   v6_q;
  tun_norm_t              pay6_q;
  logic [2*RedW-1:0]      sq_q [3];
  // root pipeline, entry 0 is the sum stage
  logic                   rv_q   [RootW+1];
  tun_norm_t              rp_q   [RootW+1];
  logic [SumW-1:0]        rs_q   [RootW+1];
  logic [RemW-1:0]        rr_q   [RootW+1];
  logic [RootW-1:0]       rt_q   [RootW+1];
  logic [SumW-1:0]        rs_d   [1:RootW];
  logic [RemW-1:0]        rr_d   [1:RootW];
  logic [RootW-1:0]       rt_d   [1:RootW];
  // divide pipeline, entry 0 is the setup stage
  logic                   dv_q   [QuotW+1];
  tun_norm_t              dp_q   [QuotW+1];
  logic [RootW-1:0]       dl_q   [QuotW+1];
  logic [RootW-1:0]       dr_q   [QuotW+1][3];
  logic [QuotW-1:0]       dn_q   [QuotW+1][3];
  logic [RootW-1:0]       dr_d   [1:QuotW][3];
  logic [QuotW-1:0]       dn_d   [1:QuotW][3];
  // output register
  logic                   out_v_q;
  logic [OutW-1:0]        out_q [3];
  logic                   out_degen_q;

  logic [Cw-1:0] crd [9];
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      crd[i] = data_i[i*Cw +: Cw];
    end
  end

  // combinational helpers of stages 3 to 5
  logic signed [CrsW-1:0] n3 [3];
  logic [CrsW-1:0]        or4;
  logic [LenW-1:0]        bl4;
  logic [ExtW-1:0]        sh5 [3];
  logic [LenW-1:0]        amt5;

  always_comb begin
    n3[0] = {p_q[0][PrdW-1], p_q[0]} - {p_q[1][PrdW-1], p_q[1]};
    n3[1] = {p_q[2][PrdW-1], p_q[2]} - {p_q[3][PrdW-1], p_q[3]};
    n3[2] = {p_q[4][PrdW-1], p_q[4]} - {p_q[5][PrdW-1], p_q[5]};
    or4   = m3_q[0] | m3_q[1] | m3_q[2];
    bl4   = '0;
    for (int i = 0; i < CrsW; i++) begin
      if (or4[i]) begin
        bl4 = LenW'(i + 1);
      end
    end
    // bring the largest magnitude to 31 bits
    if (bl_q <= LenW'(RedW)) begin
      amt5 = LenW'(RedW) - bl_q;
      for (int k = 0; k < 3; k++) begin
        sh5[k] = ExtW'(m4_q[k]) << amt5;
      end
    end else begin
      amt5 = bl_q - LenW'(RedW);
      for (int k = 0; k < 3; k++) begin
        sh5[k] = ExtW'(m4_q[k]) >> amt5;
      end
    end
  end

  // restoring square root, two radicand bits a stage
  logic [RemW+1:0] rtmp, rtrial;
  always_comb begin
    rtmp   = '0;
    rtrial = '0;
    for (int k = 1; k <= RootW; k++) begin
      rtmp   = {rr_q[k-1], rs_q[k-1][SumW-1 -: 2]};
      rtrial = {2'b00, rt_q[k-1], 2'b01};
      if (rtmp >= rtrial) begin
        rr_d[k] = RemW'(rtmp - rtrial);
        rt_d[k] = {rt_q[k-1][RootW-2:0], 1'b1};
      end else begin
        rr_d[k] = RemW'(rtmp);
        rt_d[k] = {rt_q[k-1][RootW-2:0], 1'b0};
      end
      rs_d[k] = {rs_q[k-1][SumW-3:0], 2'b00};
    end
  end

  // restoring divide, one quotient bit a stage on three lanes
  logic [RootW:0] dtmp;
  always_comb begin
    dtmp = '0;
    for (int j = 1; j <= QuotW; j++) begin
      for (int k = 0; k < 3; k++) begin
        dtmp = {dr_q[j-1][k], dn_q[j-1][k][QuotW-1]};
        if (dtmp >= {1'b0, dl_q[j-1]}) begin
          dr_d[j][k] = RootW'(dtmp - {1'b0, dl_q[j-1]});
          dn_d[j][k] = {dn_q[j-1][k][QuotW-2:0], 1'b1};
        end else begin
          dr_d[j][k] = RootW'(dtmp);
          dn_d[j][k] = {dn_q[j-1][k][QuotW-2:0], 1'b0};
        end
      end
    end
  end

  logic [RootW-1:0] len0;
  logic [NumW-1:0]  num0 [3];
  always_comb begin
    len0 = (rt_q[RootW] == '0) ? RootW'(1) : rt_q[RootW];
    for (int k = 0; k < 3; k++) begin
      num0[k] = {1'b0, rp_q[RootW].r[k], {FracW{1'b0}}} + NumW'(len0 >> 1);
    end
  end

  logic [OutW-1:0] res [3];
  logic [QuotW-1:0] q;
  always_comb begin
    q = '0;
    for (int k = 0; k < 3; k++) begin
      q = dn_q[QuotW][k];
      if (dp_q[QuotW].degen) begin
        res[k] = '0;
      end else if (dp_q[QuotW].neg[k]) begin
        res[k] = (q > QuotW'(32768)) ? 16'h8000 : OutW'(17'h10000 - 17'(q));
      end else begin
        res[k] = (q > QuotW'(32767)) ? 16'h7fff : OutW'(q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
      v6_q    <= 1'b0;
      out_v_q <= 1'b0;
      for (int k = 0; k <= RootW; k++) begin
        rv_q[k] <= 1'b0;
      end
      for (int j = 0; j <= QuotW; j++) begin
        dv_q[j] <= 1'b0;
      end
    end else if (en) begin
      v1_q    <= valid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      v5_q    <= v4_q;
      v6_q    <= v5_q;
      rv_q[0] <= v6_q;
      for (int k = 1; k <= RootW; k++) begin
        rv_q[k] <= rv_q[k-1];
      end
      dv_q[0] <= rv_q[RootW];
      for (int j = 1; j <= QuotW; j++) begin
        dv_q[j] <= dv_q[j-1];
      end
      out_v_q <= dv_q[QuotW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        u_q[k] <= $signed({crd[3+k][Cw-1], crd[3+k]}) - $signed({crd[k][Cw-1], crd[k]});
        w_q[k] <= $signed({crd[6+k][Cw-1], crd[6+k]}) - $signed({crd[k][Cw-1], crd[k]});
      end
      p_q[0] <= u_q[1] * w_q[2];
      p_q[1] <= u_q[2] * w_q[1];
      p_q[2] <= u_q[2] * w_q[0];
      p_q[3] <= u_q[0] * w_q[2];
      p_q[4] <= u_q[0] * w_q[1];
      p_q[5] <= u_q[1] * w_q[0];
      for (int k = 0; k < 3; k++) begin
        m3_q[k]   <= n3[k][CrsW-1] ? CrsW'(-n3[k]) : CrsW'(n3[k]);
        neg3_q[k] <= n3[k][CrsW-1];
        m4_q[k]   <= m3_q[k];
        pay5_q.r[k] <= sh5[k][RedW-1:0];
        sq_q[k]   <= pay5_q.r[k] * pay5_q.r[k];
      end
      neg4_q       <= neg3_q;
      bl_q         <= bl4;
      pay5_q.neg   <= neg4_q;
      pay5_q.degen <= (bl_q == '0);
      pay6_q       <= pay5_q;
      rp_q[0] <= pay6_q;
      rs_q[0] <= SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);
      rr_q[0] <= '0;
      rt_q[0] <= '0;
      for (int k = 1; k <= RootW; k++) begin
        rp_q[k] <= rp_q[k-1];
        rs_q[k] <= rs_d[k];
        rr_q[k] <= rr_d[k];
        rt_q[k] <= rt_d[k];
      end
      dp_q[0] <= rp_q[RootW];
      dl_q[0] <= len0;
      for (int k = 0; k < 3; k++) begin
        dr_q[0][k] <= RootW'(num0[k][NumW-1:QuotW]);
        dn_q[0][k] <= num0[k][QuotW-1:0];
      end
      for (int j = 1; j <= QuotW; j++) begin
        dp_q[j] <= dp_q[j-1];
        dl_q[j] <= dl_q[j-1];
        for (int k = 0; k < 3; k++) begin
          dr_q[j][k] <= dr_d[j][k];
          dn_q[j][k] <= dn_d[j][k];
        end
      end
      for (int k = 0; k < 3; k++) begin
        out_q[k] <= res[k];
      end
      out_degen_q <= dp_q[QuotW].degen;
    end
  end

  assign valid_o      = out_v_q;
  assign normal_x_o   = out_q[0];
  assign normal_y_o   = out_q[1];
  assign normal_z_o   = out_q[2];
  assign degenerate_o = out_degen_q;

endmodule
